[hw/rtl/tsrs_pkg.sv]
// types, codes and constants shared by the time-sync refresh supervisor
// no dependencies; compiled before every other file of the block
`default_nettype none

package tsrs_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int UTC_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STATE_W   = 3;
    localparam int TEST_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRY_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_PERIOD = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] TRY_TIMEOUT_RST  = 32'd5000;
    localparam logic [CFG_W-1:0] REFRESH_RST      = 32'd3600000;
    localparam logic [CFG_W-1:0] ERROR_PERIOD_RST = 32'd60000;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIME  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd3;

    // reported state codes
    localparam logic [STATE_W-1:0] ST_NOT_READY = 3'd0;
    localparam logic [STATE_W-1:0] ST_WAIT      = 3'd1;
    localparam logic [STATE_W-1:0] ST_SUCCESS   = 3'd2;
    localparam logic [STATE_W-1:0] ST_ERROR     = 3'd3;
    localparam logic [STATE_W-1:0] ST_TEST      = 3'd4;

    // server test status codes
    localparam logic [TEST_W-1:0] TEST_FAILED  = 2'd0;
    localparam logic [TEST_W-1:0] TEST_PASSED  = 2'd1;
    localparam logic [TEST_W-1:0] TEST_PENDING = 2'd2;

    typedef enum logic [3:0] {
        KIND_TICK  = 4'b0001,
        KIND_TIME  = 4'b0010,
        KIND_TEST  = 4'b0100,
        KIND_RESET = 4'b1000
    } t_kind;

    typedef enum logic [4:0] {
        MODE_NOT_READY = 5'b00001,
        MODE_WAIT      = 5'b00010,
        MODE_SUCCESS   = 5'b00100,
        MODE_ERROR     = 5'b01000,
        MODE_TEST      = 5'b10000
    } t_mode;

    typedef struct packed {
        t_kind            kind;
        logic             ready;
        logic [UTC_W-1:0] utc;
    } t_item;

    typedef struct packed {
        logic               stop_client;
        logic               start_client;
        logic               set_clock;
        logic [UTC_W-1:0]   clock_utc;
        logic               refresh_failed;
        logic [STATE_W-1:0] state_now;
        logic               test_done;
        logic               test_passed;
        logic               last_of_run;
    } t_result;

    function automatic logic [STATE_W-1:0] mode_code(input t_mode m);
        logic [STATE_W-1:0] c;
        case (m)
            MODE_WAIT:    c = ST_WAIT;
            MODE_SUCCESS: c = ST_SUCCESS;
            MODE_ERROR:   c = ST_ERROR;
            MODE_TEST:    c = ST_TEST;
            default:      c = ST_NOT_READY;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tsrs_front.sv]
// front end: input register stage that takes transfers and classifies the command
// depends on tsrs_pkg
`default_nettype none

module tsrs_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [tsrs_pkg::CMD_W-1:0] i_command,
    input  wire logic                      i_service_ready,
    input  wire logic [tsrs_pkg::UTC_W-1:0] i_utc_seconds,
    output logic                           o_item_valid,
    output tsrs_pkg::t_item                o_item,
    input  wire logic                      i_item_ready
);
    import tsrs_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_in_ready   = !r_valid || i_item_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        case (i_command)
            CMD_TICK: n_item.kind = KIND_TICK;
            CMD_TIME: n_item.kind = KIND_TIME;
            CMD_TEST: n_item.kind = KIND_TEST;
            default:  n_item.kind = KIND_RESET;
        endcase
        n_item.ready = i_service_ready;
        // the time only matters for a received-time event
        n_item.utc   = (i_command == CMD_TIME) ? i_utc_seconds : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsrs_fifo.sv]
// small register queue with a typed payload, used between the stages
// no package dependency
`default_nettype none

module tsrs_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  T          i_data,
    output logic      o_ready,
    output logic      o_valid,
    output T          o_data,
    input  wire logic i_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsrs_back.sv]
// back end: configuration registers, timers, mode machine and event sequencer
// depends on tsrs_pkg; one internal event is carried out per cycle unless the result queue is full
`default_nettype none

module tsrs_back #(
    parameter int RETRY_COUNT = 3,
    parameter int TIMER_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tsrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tsrs_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_q_valid,
    input  tsrs_pkg::t_item                    i_q_item,
    output logic                               o_q_pop,
    input  wire logic                          i_res_ready,
    output logic                               o_res_push,
    output tsrs_pkg::t_result                  o_res
);
    import tsrs_pkg::*;

    localparam int TW      = TIMER_WIDTH;
    localparam int RC_W    = $clog2(RETRY_COUNT + 1);
    localparam int PROD_W  = CFG_W + RC_W;
    localparam int SREG_W  = (CFG_W > TW) ? CFG_W : TW;
    localparam int SPROD_W = (PROD_W > TW) ? PROD_W : TW;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_EVENT    = 4'b0010,
        PH_TRY      = 4'b0100,
        PH_DEADLINE = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_READY,
        EV_NOT_READY,
        EV_GOT_TIME,
        EV_TEST,
        EV_TRY_OUT,
        EV_DEADLINE,
        EV_RESET
    } t_event;

    function automatic logic [TW-1:0] sat_reg(input logic [CFG_W-1:0] v);
        logic [SREG_W-1:0] ext;
        logic [SREG_W-1:0] lim;
        ext = SREG_W'(v);
        lim = SREG_W'({TW{1'b1}});
        return (ext > lim) ? lim[TW-1:0] : ext[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] sat_prod(input logic [PROD_W-1:0] v);
        logic [SPROD_W-1:0] ext;
        logic [SPROD_W-1:0] lim;
        ext = SPROD_W'(v);
        lim = SPROD_W'({TW{1'b1}});
        return (ext > lim) ? lim[TW-1:0] : ext[TW-1:0];
    endfunction

    // configuration and derived timer loads
    logic [CFG_W-1:0]  r_try_timeout;
    logic [CFG_W-1:0]  r_refresh;
    logic [CFG_W-1:0]  r_err_period;
    logic [PROD_W-1:0] r_dl_prod;
    logic [TW-1:0]     r_try_load;
    logic [TW-1:0]     r_ref_load;
    logic [TW-1:0]     r_err_load;
    logic [TW-1:0]     r_dl_load;

    // supervisor state
    t_mode             r_mode;
    logic [TW-1:0]     r_try;
    logic              r_try_armed;
    logic [TW-1:0]     r_dl;
    logic              r_dl_armed;
    logic [TEST_W-1:0] r_test;
    t_phase            r_phase;
    t_item             r_item;

    // step logic
    t_event            ev;
    logic [TW-1:0]     try_base;
    logic [TW-1:0]     dl_base;
    logic              try_armed_base;
    logic              dl_armed_base;
    logic [TEST_W-1:0] test_base;
    t_mode             n_mode;
    logic [TW-1:0]     n_try;
    logic              n_try_armed;
    logic [TW-1:0]     n_dl;
    logic              n_dl_armed;
    logic [TEST_W-1:0] n_test;
    t_phase            n_phase;
    logic              stop;
    logic              start;
    logic              setclk;
    logic              failed;
    logic              do_wait;
    logic              do_test;
    logic              try_fire;
    logic              dl_fire;
    logic              has_res;
    logic              item_done;
    logic              step_go;

    // timer base after the tick countdown or the disarm of the firing timer
    always_comb begin
        try_base       = r_try;
        dl_base        = r_dl;
        try_armed_base = r_try_armed;
        dl_armed_base  = r_dl_armed;
        test_base      = r_test;
        ev             = EV_NONE;
        case (r_phase)
            PH_EVENT: begin
                case (r_item.kind)
                    KIND_TICK: begin
                        if (r_try_armed && (r_try != '0)) begin
                            try_base = r_try - TW'(1);
                        end
                        if (r_dl_armed && (r_dl != '0)) begin
                            dl_base = r_dl - TW'(1);
                        end
                        if (r_mode == MODE_NOT_READY) begin
                            if (r_item.ready) begin
                                ev = EV_READY;
                            end
                        end else if (!r_item.ready) begin
                            ev = EV_NOT_READY;
                        end
                    end
                    KIND_TIME: ev = EV_GOT_TIME;
                    KIND_TEST: begin
                        test_base = TEST_PENDING;
                        ev        = EV_TEST;
                    end
                    default: ev = EV_RESET;
                endcase
            end
            PH_TRY: begin
                try_armed_base = 1'b0;
                ev             = EV_TRY_OUT;
            end
            PH_DEADLINE: begin
                dl_armed_base = 1'b0;
                ev            = EV_DEADLINE;
            end
            default: ev = EV_NONE;
        endcase
    end

    // event dispatch on the mode machine
    always_comb begin
        n_mode      = r_mode;
        n_try       = try_base;
        n_try_armed = try_armed_base;
        n_dl        = dl_base;
        n_dl_armed  = dl_armed_base;
        n_test      = test_base;
        stop        = 1'b0;
        start       = 1'b0;
        setclk      = 1'b0;
        failed      = 1'b0;
        do_wait     = 1'b0;
        do_test     = 1'b0;
        case (r_mode)
            MODE_WAIT: begin
                case (ev)
                    EV_NOT_READY: begin
                        stop   = 1'b1;
                        n_mode = MODE_NOT_READY;
                    end
                    EV_GOT_TIME: begin
                        stop        = 1'b1;
                        setclk      = 1'b1;
                        n_try       = r_ref_load;
                        n_try_armed = 1'b1;
                        n_mode      = MODE_SUCCESS;
                    end
                    EV_TEST: begin
                        stop    = 1'b1;
                        do_test = 1'b1;
                    end
                    EV_TRY_OUT: begin
                        stop        = 1'b1;
                        start       = 1'b1;
                        n_try       = r_try_load;
                        n_try_armed = 1'b1;
                    end
                    EV_DEADLINE: begin
                        stop        = 1'b1;
                        failed      = 1'b1;
                        n_try       = r_err_load;
                        n_try_armed = 1'b1;
                        n_mode      = MODE_ERROR;
                    end
                    EV_RESET: begin
                        stop    = 1'b1;
                        do_wait = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_SUCCESS, MODE_ERROR: begin
                case (ev)
                    EV_TEST:              do_test = 1'b1;
                    EV_TRY_OUT, EV_RESET: do_wait = 1'b1;
                    default: ;
                endcase
            end
            MODE_TEST: begin
                case (ev)
                    EV_NOT_READY: begin
                        stop   = 1'b1;
                        n_test = TEST_FAILED;
                        n_mode = MODE_NOT_READY;
                    end
                    EV_GOT_TIME: begin
                        stop    = 1'b1;
                        n_test  = TEST_PASSED;
                        do_wait = 1'b1;
                    end
                    EV_TEST: begin
                        stop    = 1'b1;
                        do_test = 1'b1;
                    end
                    EV_TRY_OUT: begin
                        n_test  = TEST_FAILED;
                        do_wait = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: begin
                if (ev == EV_READY) begin
                    do_wait = 1'b1;
                end
            end
        endcase
        // fresh refresh: new try and a new overall deadline
        if (do_wait) begin
            start       = 1'b1;
            n_try       = r_try_load;
            n_try_armed = 1'b1;
            n_dl        = r_dl_load;
            n_dl_armed  = 1'b1;
            n_mode      = MODE_WAIT;
        end
        // server test: new try, deadline left alone
        if (do_test) begin
            start       = 1'b1;
            n_try       = r_try_load;
            n_try_armed = 1'b1;
            n_mode      = MODE_TEST;
        end
    end

    // look ahead at which timer checks of a tick still fire
    always_comb begin
        try_fire = n_try_armed && (n_try == '0);
        dl_fire  = n_dl_armed && (n_dl == '0);
        n_phase  = PH_IDLE;
        case (r_phase)
            PH_EVENT: begin
                if (r_item.kind == KIND_TICK) begin
                    if (try_fire) begin
                        n_phase = PH_TRY;
                    end else if (dl_fire) begin
                        n_phase = PH_DEADLINE;
                    end
                end
            end
            PH_TRY: begin
                if (dl_fire) begin
                    n_phase = PH_DEADLINE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    assign has_res    = (ev != EV_NONE);
    assign item_done  = (n_phase == PH_IDLE);
    assign step_go    = (r_phase != PH_IDLE) && (!has_res || i_res_ready);
    assign o_res_push = step_go && has_res;
    assign o_q_pop    = i_q_valid && ((r_phase == PH_IDLE) || (step_go && item_done));

    always_comb begin
        o_res.stop_client    = stop;
        o_res.start_client   = start;
        o_res.set_clock      = setclk;
        o_res.clock_utc      = setclk ? r_item.utc : '0;
        o_res.refresh_failed = failed;
        o_res.state_now      = mode_code(n_mode);
        o_res.test_done      = (n_test != TEST_PENDING);
        o_res.test_passed    = (n_test == TEST_PASSED);
        o_res.last_of_run    = item_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_try_timeout <= TRY_TIMEOUT_RST;
            r_refresh     <= REFRESH_RST;
            r_err_period  <= ERROR_PERIOD_RST;
            r_mode        <= MODE_NOT_READY;
            r_try         <= '0;
            r_try_armed   <= 1'b0;
            r_dl          <= '0;
            r_dl_armed    <= 1'b0;
            r_test        <= TEST_FAILED;
            r_phase       <= PH_IDLE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TRY_TIMEOUT:  r_try_timeout <= i_cfg_wdata;
                    CFG_REFRESH:      r_refresh     <= i_cfg_wdata;
                    CFG_ERROR_PERIOD: r_err_period  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (step_go) begin
                r_mode      <= n_mode;
                r_try       <= n_try;
                r_try_armed <= n_try_armed;
                r_dl        <= n_dl;
                r_dl_armed  <= n_dl_armed;
                r_test      <= n_test;
            end
            if (o_q_pop) begin
                r_phase <= PH_EVENT;
            end else if (step_go) begin
                r_phase <= n_phase;
            end
        end
    end

    // timer loads follow the registers; product then saturation
    always_ff @(posedge i_clk) begin
        r_dl_prod  <= PROD_W'(r_try_timeout) * PROD_W'(RETRY_COUNT);
        r_dl_load  <= sat_prod(r_dl_prod);
        r_try_load <= sat_reg(r_try_timeout);
        r_ref_load <= sat_reg(r_refresh);
        r_err_load <= sat_reg(r_err_period);
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/time_sync_refresh_supervisor.sv]
// top level of the time-sync refresh supervisor: front stage, item queue,
// sequencer and result queue; depends on tsrs_pkg, tsrs_front, tsrs_fifo, tsrs_back
//
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    i_command, i_service_ready, i_utc_seconds
//  result    o_out_valid / i_out_ready  o_stop_client .. o_last_of_run
//  config    i_cfg_we (no wait)         i_cfg_idx, i_cfg_wdata
//
// a tick is worked off as a ready check, then a try timer check and then a deadline
// check, each only if its timer fires; a time, test or reset command needs no timer check
// the sequencer is the limiting unit
// an item is registered in the front stage, the item queue and the sequencer in turn
// reset is synchronous and active low; there is no clearing pass
// a full result queue stalls the sequencer, a full item queue stalls the input
`default_nettype none

module time_sync_refresh_supervisor #(
    parameter int RETRY_COUNT = 3,
    parameter int TIMER_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [tsrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tsrs_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tsrs_pkg::CMD_W-1:0]    i_command,
    input  wire logic                          i_service_ready,
    input  wire logic [tsrs_pkg::UTC_W-1:0]    i_utc_seconds,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_stop_client,
    output logic                               o_start_client,
    output logic                               o_set_clock,
    output logic [tsrs_pkg::UTC_W-1:0]         o_clock_utc,
    output logic                               o_refresh_failed,
    output logic [tsrs_pkg::STATE_W-1:0]       o_state_now,
    output logic                               o_test_done,
    output logic                               o_test_passed,
    output logic                               o_last_of_run
);
    import tsrs_pkg::*;

    // front stage to item queue
    logic    fr_valid;
    logic    fr_ready;
    t_item   fr_item;
    // item queue to sequencer
    logic    q_valid;
    logic    q_pop;
    t_item   q_item;
    // sequencer to result queue
    logic    res_push;
    logic    res_ready;
    t_result res;
    t_result out_res;

    // decode each input transfer into an item
    tsrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_service_ready(i_service_ready),
        .i_utc_seconds  (i_utc_seconds),
        .o_item_valid   (fr_valid),
        .o_item         (fr_item),
        .i_item_ready   (fr_ready)
    );

    // short queue so the front keeps taking items while a tick is worked off
    tsrs_fifo #(
        .T    (t_item),
        .DEPTH(2)
    ) u_item_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fr_valid),
        .i_data (fr_item),
        .o_ready(fr_ready),
        .o_valid(q_valid),
        .o_data (q_item),
        .i_pop  (q_pop)
    );

    // timers, mode machine, one event per cycle unless the result queue is full
    tsrs_back #(
        .RETRY_COUNT(RETRY_COUNT),
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .i_res_ready(res_ready),
        .o_res_push (res_push),
        .o_res      (res)
    );

    // result queue parts the sequencer from the downstream handshake
    tsrs_fifo #(
        .T    (t_result),
        .DEPTH(2)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .o_ready(res_ready),
        .o_valid(o_out_valid),
        .o_data (out_res),
        .i_pop  (i_out_ready)
    );

    assign o_stop_client    = out_res.stop_client;
    assign o_start_client   = out_res.start_client;
    assign o_set_clock      = out_res.set_clock;
    assign o_clock_utc      = out_res.clock_utc;
    assign o_refresh_failed = out_res.refresh_failed;
    assign o_state_now      = out_res.state_now;
    assign o_test_done      = out_res.test_done;
    assign o_test_passed    = out_res.test_passed;
    assign o_last_of_run    = out_res.last_of_run;

endmodule

`default_nettype wire

[hw/rtl/tsrs_checker.sv]
// port-level checks on the result channel of the supervisor, bound to the top level
// depends on tsrs_pkg and time_sync_refresh_supervisor
`default_nettype none

module tsrs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_stop_client,
    input wire logic                          o_start_client,
    input wire logic                          o_set_clock,
    input wire logic [tsrs_pkg::UTC_W-1:0]    o_clock_utc,
    input wire logic                          o_refresh_failed,
    input wire logic [tsrs_pkg::STATE_W-1:0]  o_state_now,
    input wire logic                          o_test_done,
    input wire logic                          o_test_passed,
    input wire logic                          o_last_of_run
);
    import tsrs_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable({o_stop_client,
            o_start_client, o_set_clock, o_clock_utc, o_refresh_failed, o_state_now,
            o_test_done, o_test_passed, o_last_of_run}))
        else $error("result changed while stalled");

    // clock load only on a received time, which lands in success
    a_setclk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_set_clock |-> o_stop_client && (o_state_now == ST_SUCCESS))
        else $error("set clock outside a success transition");

    // time is zero unless loaded
    a_utc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_set_clock |-> (o_clock_utc == '0))
        else $error("clock time without set clock");

    // a failed refresh stops the client and enters error
    a_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refresh_failed |-> o_stop_client && !o_start_client
            && (o_state_now == ST_ERROR))
        else $error("refresh failure without error state");

    // a pending test never reads as passed
    a_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_test_done |-> !o_test_passed)
        else $error("test passed while pending");

endmodule

bind time_sync_refresh_supervisor tsrs_checker u_tsrs_checker (.*);

`default_nettype wire
